// ===== rtl/core/drk_pkg.sv =====
// ----------------------------------------------------------------------------
// DER RSA key parser package
// Shared types and codes for the byte-serial key parser.
// ----------------------------------------------------------------------------
`default_nettype none

package drk_pkg;

  localparam logic [7:0] TagSequence = 8'h30;
  localparam logic [7:0] TagInteger  = 8'h02;
  localparam logic [7:0] LenLong1    = 8'h81;
  localparam logic [7:0] LenLong2    = 8'h82;
  localparam logic [7:0] VersionZero = 8'h00;

  localparam logic [3:0] LastIdxPriv = 4'd8;
  localparam logic [3:0] LastIdxPub  = 4'd1;

  localparam logic KindPrivate = 1'b0;
  localparam logic KindPublic  = 1'b1;

  typedef enum logic [2:0] {
    ST_FOUND     = 3'd0,
    ST_NO_SEQ    = 3'd1,
    ST_BAD_OUTER = 3'd2,
    ST_WRONG_TAG = 3'd3,
    ST_BAD_VER   = 3'd4,
    ST_TRUNC     = 3'd5,
    ST_EMPTY_MOD = 3'd6,
    ST_TOO_LONG  = 3'd7
  } status_e;

  typedef struct packed {
    logic [7:0] key_byte;
    logic       first_byte;
    logic       last_byte;
  } item_t;

  typedef struct packed {
    logic [15:0] value_length;
    logic [15:0] value_offset;
    logic [2:0]  component;
    status_e     status;
    logic        final_res;
  } res_t;

  typedef struct packed {
    logic valid;
    res_t res;
  } res_pkt_t;

endpackage

`default_nettype wire

// ===== rtl/core/drk_in_stage.sv =====
// ----------------------------------------------------------------------------
// DER RSA key parser input stage
// Registers one key byte transfer and holds it until the parser takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module drk_in_stage
  import drk_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  valid_i,
  output logic       ready_o,
  input  wire item_t item_i,
  input  wire logic  advance_i,
  output logic       valid_o,
  output item_t      item_o
);

  logic  vld_q, vld_d;
  item_t item_q;

  assign ready_o = !vld_q || advance_i;
  assign vld_d   = (valid_i && ready_o) ? 1'b1 : (advance_i ? 1'b0 : vld_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      item_q <= item_i;
    end
  end

  assign valid_o = vld_q;
  assign item_o  = item_q;

endmodule

`default_nettype wire

// ===== rtl/core/drk_parser.sv =====
// ----------------------------------------------------------------------------
// DER RSA key parser core
// Per-byte header walk: sequence search, element headers, value counting.
// ----------------------------------------------------------------------------
`default_nettype none

module drk_parser
  import drk_pkg::*;
#(
  parameter int TAG_SEARCH_BYTES = 8,
  parameter int OFFSET_BITS      = 16
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  cfg_we_i,
  input  wire logic  cfg_wdata_i,
  input  wire logic  step_i,
  input  wire item_t item_i,
  output res_pkt_t   pkt_o
);

  localparam int PosW = OFFSET_BITS + 1;
  localparam logic [PosW-1:0] SeekLast = PosW'(TAG_SEARCH_BYTES - 1);

  localparam logic [2:0] PhSeek      = 3'd0;
  localparam logic [2:0] PhOuterLen  = 3'd1;
  localparam logic [2:0] PhOuterSkip = 3'd2;
  localparam logic [2:0] PhTag       = 3'd3;
  localparam logic [2:0] PhLen       = 3'd4;
  localparam logic [2:0] PhLenExt    = 3'd5;
  localparam logic [2:0] PhValue     = 3'd6;

  logic            kind_q;
  logic [2:0]      phase_q, phase_d, e_phase;
  logic [PosW-1:0] pos_q, pos_d, e_pos, pos_inc;
  logic [3:0]      fi_q, fi_d, e_fi;
  logic [15:0]     acc_q, acc_d, e_acc;
  logic [15:0]     rem_q, rem_d, e_rem, rem_dec;
  logic [PosW-1:0] vs_q, vs_d, e_vs;
  logic            fin_q, fin_d, e_fin;

  logic            is_ver, hdr_go, fld_go, fail_go, pub_n, last_fld;
  logic [15:0]     hdr_len, fld_len, ext_acc;
  logic [PosW-1:0] fld_start;
  status_e         fail_st;
  res_pkt_t        pkt;

  function automatic logic [15:0] low16(input logic [PosW-1:0] p);
    logic [PosW+15:0] t;
    t = {16'b0, p};
    return t[15:0];
  endfunction

  always_comb begin
    if (item_i.first_byte) begin
      e_phase = PhSeek;
      e_pos   = '0;
      e_fi    = '0;
      e_acc   = '0;
      e_rem   = '0;
      e_vs    = '0;
      e_fin   = 1'b0;
    end else begin
      e_phase = phase_q;
      e_pos   = pos_q;
      e_fi    = fi_q;
      e_acc   = acc_q;
      e_rem   = rem_q;
      e_vs    = vs_q;
      e_fin   = fin_q;
    end
  end

  assign pos_inc = e_pos + PosW'(1);
  assign rem_dec = e_rem - 16'd1;
  assign ext_acc = {e_acc[7:0], item_i.key_byte};
  assign is_ver  = (kind_q == KindPrivate) && (e_fi == 4'd0);

  always_comb begin
    phase_d   = e_phase;
    pos_d     = e_pos;
    fi_d      = e_fi;
    acc_d     = e_acc;
    rem_d     = e_rem;
    vs_d      = e_vs;
    fin_d     = e_fin;
    hdr_go    = 1'b0;
    hdr_len   = '0;
    fld_go    = 1'b0;
    fld_start = e_vs;
    fld_len   = e_acc;
    fail_go   = 1'b0;
    fail_st   = ST_FOUND;
    pub_n     = 1'b0;
    last_fld  = 1'b0;
    pkt       = '0;
    if (!e_fin) begin
      if (e_pos[OFFSET_BITS]) begin
        fail_go = 1'b1;
        fail_st = ST_TOO_LONG;
      end else begin
        pos_d = pos_inc;
        unique case (e_phase)
          PhSeek: begin
            if (item_i.key_byte == TagSequence) begin
              phase_d = PhOuterLen;
            end else if (e_pos >= SeekLast) begin
              fail_go = 1'b1;
              fail_st = ST_NO_SEQ;
            end
          end
          PhOuterLen: begin
            if (item_i.key_byte == LenLong2) begin
              rem_d   = 16'd2;
              phase_d = PhOuterSkip;
            end else if (item_i.key_byte == LenLong1) begin
              rem_d   = 16'd1;
              phase_d = PhOuterSkip;
            end else begin
              fail_go = 1'b1;
              fail_st = ST_BAD_OUTER;
            end
          end
          PhOuterSkip: begin
            rem_d = rem_dec;
            if (rem_dec == 16'd0) begin
              phase_d = PhTag;
            end
          end
          PhTag: begin
            if (item_i.key_byte == TagInteger) begin
              phase_d = PhLen;
            end else begin
              fail_go = 1'b1;
              fail_st = ST_WRONG_TAG;
            end
          end
          PhLen: begin
            if (item_i.key_byte == LenLong2 || item_i.key_byte == LenLong1) begin
              rem_d   = (item_i.key_byte == LenLong2) ? 16'd2 : 16'd1;
              acc_d   = '0;
              phase_d = PhLenExt;
            end else begin
              hdr_go  = 1'b1;
              hdr_len = {8'b0, item_i.key_byte};
            end
          end
          PhLenExt: begin
            acc_d = ext_acc;
            rem_d = rem_dec;
            if (rem_dec == 16'd0) begin
              hdr_go  = 1'b1;
              hdr_len = ext_acc;
            end
          end
          default: begin
            if (is_ver && item_i.key_byte != VersionZero) begin
              fail_go = 1'b1;
              fail_st = ST_BAD_VER;
            end else begin
              rem_d = rem_dec;
              if (rem_dec == 16'd0) begin
                fld_go = 1'b1;
              end
            end
          end
        endcase
      end

      if (hdr_go) begin
        acc_d = hdr_len;
        rem_d = hdr_len;
        vs_d  = pos_inc;
        priority if (is_ver && hdr_len != 16'd1) begin
          fail_go = 1'b1;
          fail_st = ST_BAD_VER;
        end else if (kind_q == KindPublic && e_fi == 4'd0 && hdr_len == 16'd0) begin
          fail_go = 1'b1;
          fail_st = ST_EMPTY_MOD;
        end else if (hdr_len == 16'd0) begin
          fld_go    = 1'b1;
          fld_start = pos_inc;
          fld_len   = hdr_len;
        end else begin
          phase_d = PhValue;
        end
      end

      if (fld_go) begin
        phase_d = PhTag;
        if (is_ver) begin
          fi_d = 4'd1;
        end else begin
          pub_n    = (kind_q == KindPublic) && (e_fi == 4'd0);
          last_fld = (e_fi == ((kind_q == KindPublic) ? LastIdxPub : LastIdxPriv));
          fi_d     = e_fi + 4'd1;
          fin_d    = last_fld;
          pkt.valid            = 1'b1;
          pkt.res.status       = ST_FOUND;
          pkt.res.component    = (kind_q == KindPublic) ? e_fi[2:0] : e_fi[2:0] - 3'd1;
          pkt.res.value_offset = low16(fld_start) + {15'b0, pub_n};
          pkt.res.value_length = fld_len - {15'b0, pub_n};
          pkt.res.final_res    = last_fld;
        end
      end

      if (fail_go) begin
        fin_d = 1'b1;
        pkt   = '0;
        pkt.valid            = 1'b1;
        pkt.res.status       = fail_st;
        pkt.res.value_offset = low16(e_pos);
        pkt.res.final_res    = 1'b1;
      end

      if (item_i.last_byte && !fin_d) begin
        fin_d = 1'b1;
        pkt   = '0;
        pkt.valid            = 1'b1;
        pkt.res.status       = ST_TRUNC;
        pkt.res.value_offset = low16(e_pos);
        pkt.res.final_res    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q <= KindPrivate;
    end else if (cfg_we_i) begin
      kind_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhSeek;
      pos_q   <= '0;
      fi_q    <= '0;
      acc_q   <= '0;
      rem_q   <= '0;
      vs_q    <= '0;
      fin_q   <= 1'b0;
    end else if (step_i) begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      fi_q    <= fi_d;
      acc_q   <= acc_d;
      rem_q   <= rem_d;
      vs_q    <= vs_d;
      fin_q   <= fin_d;
    end
  end

  assign pkt_o = pkt;

endmodule

`default_nettype wire

// ===== rtl/core/drk_out_stage.sv =====
// ----------------------------------------------------------------------------
// DER RSA key parser output stage
// Holds one result until the downstream side takes the transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module drk_out_stage
  import drk_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     load_i,
  input  wire res_pkt_t pkt_i,
  input  wire logic     ready_i,
  output logic          valid_o,
  output res_t          res_o
);

  logic vld_q, vld_d;
  res_t res_q;

  assign vld_d = load_i ? pkt_i.valid : (ready_i ? 1'b0 : vld_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && pkt_i.valid) begin
      res_q <= pkt_i.res;
    end
  end

  assign valid_o = vld_q;
  assign res_o   = res_q;

endmodule

`default_nettype wire

// ===== rtl/core/der_rsa_key_parser.sv =====
// ----------------------------------------------------------------------------
// DER RSA key parser
// Byte-serial walk of a DER RSA key that reports each INTEGER field but the private-key version.
// ----------------------------------------------------------------------------
// One key byte is taken per clock cycle unless a result waits on
// m_axis_tready_i. A byte passes through an input register, a combinational
// header and length update, and a result register, the only thing that can
// hold the stream back: while a result waits, one more byte is still taken
// into the input register if it is empty. Errors end the key; further bytes
// are dropped until a byte with tuser set starts a new key. The user must
// write key_kind only while idle; the block itself does not enforce this.
`default_nettype none

module der_rsa_key_parser
  import drk_pkg::*;
#(
  parameter int TAG_SEARCH_BYTES = 8,
  parameter int OFFSET_BITS      = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_wdata_i,      // key_kind
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // key_byte
  input  wire logic        s_axis_tuser_i,   // first_byte
  input  wire logic        s_axis_tlast_i,   // last_byte
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [39:0]      m_axis_tdata_o,   // status, component, value_offset,
                                             // value_length, zero fill
  output logic             m_axis_tlast_o    // final_res
);

  item_t    in_item, st_item;
  logic     st_vld, advance;
  res_pkt_t pkt;
  res_t     out_res;

  assign in_item.key_byte   = s_axis_tdata_i;
  assign in_item.first_byte = s_axis_tuser_i;
  assign in_item.last_byte  = s_axis_tlast_i;

  assign advance = st_vld && (!m_axis_tvalid_o || m_axis_tready_i);

  drk_in_stage u_in (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (s_axis_tvalid_i),
    .ready_o   (s_axis_tready_o),
    .item_i    (in_item),
    .advance_i (advance),
    .valid_o   (st_vld),
    .item_o    (st_item)
  );

  drk_parser #(
    .TAG_SEARCH_BYTES (TAG_SEARCH_BYTES),
    .OFFSET_BITS      (OFFSET_BITS)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .step_i      (advance),
    .item_i      (st_item),
    .pkt_o       (pkt)
  );

  drk_out_stage u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (advance),
    .pkt_i   (pkt),
    .ready_i (m_axis_tready_i),
    .valid_o (m_axis_tvalid_o),
    .res_o   (out_res)
  );

  assign m_axis_tdata_o = {2'b00, out_res.value_length, out_res.value_offset,
                           out_res.component, out_res.status};
  assign m_axis_tlast_o = out_res.final_res;

  a_no_take_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_vld && m_axis_tvalid_o && !m_axis_tready_i |-> !s_axis_tready_o)
    else $error("byte taken while both stages are full");

  a_held_byte_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_vld && !advance |=> st_vld && $stable(st_item))
    else $error("stalled byte lost");

  a_error_is_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && out_res.status != ST_FOUND |->
      m_axis_tlast_o && out_res.value_length == 16'd0 && out_res.component == 3'd0)
    else $error("error result not final or carries field data");

  a_result_from_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(m_axis_tvalid_o) && m_axis_tvalid_o |-> $past(advance))
    else $error("result appeared without a parser step");

endmodule

`default_nettype wire
